FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ICAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ICAS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: src/icas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icas_pkg
// Shared types and constants of the infection cellular automaton step block.
// ----------------------------------------------------------------------------
package icas_pkg;

  localparam int GRID_SIDE_DEF   = 64;
  localparam int RANDOM_BITS_DEF = 16;

  localparam int COORD_W = 6;
  localparam int STATE_W = 2;
  localparam int RAND_W  = 16;
  localparam int COUNT_W = 13;
  localparam int THR_W   = 4;
  localparam int TIMER_W = 4;
  localparam int PROB_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Cell states.
  localparam logic [STATE_W-1:0] ST_HEALTHY = 2'd0;
  localparam logic [STATE_W-1:0] ST_A       = 2'd1;
  localparam logic [STATE_W-1:0] ST_B       = 2'd2;
  localparam logic [STATE_W-1:0] ST_DEAD    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAU         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_P_INFEC     = 2'd3;

  // Command handed from the front end to the back end.
  typedef struct packed {
    logic               is_update;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [STATE_W-1:0] load_state;
    logic [RAND_W-1:0]  random_value;
  } cmd_t;

  // Status from the back end to the front end.
  typedef struct packed {
    logic clearing;
  } back_stat_t;

  // Live configuration.
  typedef struct packed {
    logic [THR_W-1:0]   threshold_a;
    logic [THR_W-1:0]   threshold_b;
    logic [TIMER_W-1:0] tau;
    logic [PROB_W-1:0]  p_infec;
  } cfg_t;

endpackage

FILE: src/icas_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icas_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module icas_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One address per cycle: a registered read, plus a write when we is high; a write cycle reads the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: src/icas_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icas_front
// Accepts commands, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module icas_front
  import icas_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               mode,
  input  logic [COORD_W-1:0] cell_x,
  input  logic [COORD_W-1:0] cell_y,
  input  logic [STATE_W-1:0] load_state,
  input  logic [RAND_W-1:0]  random_value,
  output logic               busy,
  input  back_stat_t         stat,
  output logic               q_valid,
  output cmd_t               q_data,
  input  logic               q_pop
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       cmd_in;

  // Hold off new transactions while clearing or while the queue is full.
  assign busy    = stat.clearing || (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_data  = entry[rd_ptr];

  // Classify the incoming item.
  always_comb begin
    cmd_in.is_update    = mode;
    cmd_in.cell_x       = cell_x;
    cmd_in.cell_y       = cell_y;
    cmd_in.load_state   = load_state;
    cmd_in.random_value = random_value;
  end

  // Two-entry queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entry[wr_ptr] <= cmd_in;
        wr_ptr        <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: src/icas_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icas_back
// Executes queued loads and cell updates against the two-bank grid memory.
// ----------------------------------------------------------------------------
module icas_back
  import icas_pkg::*;
#(
  parameter int GRID_SIDE   = GRID_SIDE_DEF,
  parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_valid,
  input  cmd_t               q_data,
  output logic               q_pop,
  output back_stat_t         stat,
  output logic               done,
  output logic [STATE_W-1:0] new_cell_state,
  output logic               generation_done,
  output logic [COUNT_W-1:0] healthy_count,
  output logic [COUNT_W-1:0] infected_count,
  output logic [COUNT_W-1:0] dead_count
);

  localparam int CELLS  = GRID_SIDE * GRID_SIDE;
  localparam int CELL_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(GRID_SIDE);
  localparam int GADR_W = CELL_W + 1;
  localparam int CMP_W  = RANDOM_BITS + 17;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_LOAD, S_RD, S_LAST, S_EXEC} state_t;

  state_t             state;
  cmd_t               cmd;
  logic [GADR_W-1:0]  clr_cnt;
  logic               bank;
  logic [ROW_W-1:0]   row;
  logic [ROW_W-1:0]   col;
  logic [CELL_W-1:0]  idx;
  logic [3:0]         k;
  logic               rd_vld;
  logic [3:0]         rd_k;
  logic [STATE_W-1:0] own;
  logic [3:0]         na;
  logic [3:0]         nb;
  logic [COUNT_W-1:0] run_h;
  logic [COUNT_W-1:0] run_i;
  logic [COUNT_W-1:0] run_d;

  logic               g_we;
  logic [GADR_W-1:0]  g_addr;
  logic [STATE_W-1:0] g_wdata;
  logic [STATE_W-1:0] g_rdata;
  logic               t_we;
  logic [CELL_W-1:0]  t_addr;
  logic [TIMER_W-1:0] t_wdata;
  logic [TIMER_W-1:0] t_rdata;

  logic [ROW_W-1:0]   row_up;
  logic [ROW_W-1:0]   row_dn;
  logic [ROW_W-1:0]   col_lf;
  logic [ROW_W-1:0]   col_rt;
  logic [ROW_W-1:0]   nr;
  logic [ROW_W-1:0]   nc;
  logic [CELL_W-1:0]  nb_idx;
  logic               ld_in;
  logic [CELL_W-1:0]  ld_idx;
  logic [CMP_W-1:0]   rmax;
  logic [CMP_W-1:0]   r_val;
  logic [CMP_W-1:0]   lhs;
  logic [CMP_W-1:0]   rhs;
  logic [STATE_W-1:0] nxt;
  logic               t_wr;
  logic [TIMER_W-1:0] t_val;
  logic               last_cell;
  logic [COUNT_W-1:0] run_h_next;
  logic [COUNT_W-1:0] run_i_next;
  logic [COUNT_W-1:0] run_d_next;

  assign stat.clearing = (state == S_CLR);
  assign q_pop         = (state == S_IDLE) && q_valid;

  // Toroidal neighbor coordinates.
  assign row_up = (row == '0) ? ROW_W'(GRID_SIDE - 1) : row - 1'b1;
  assign row_dn = (row == ROW_W'(GRID_SIDE - 1)) ? '0 : row + 1'b1;
  assign col_lf = (col == '0) ? ROW_W'(GRID_SIDE - 1) : col - 1'b1;
  assign col_rt = (col == ROW_W'(GRID_SIDE - 1)) ? '0 : col + 1'b1;

  // Read order: own cell, then the Moore neighborhood row by row.
  always_comb begin
    case (k)
      4'd1, 4'd2, 4'd3: nr = row_up;
      4'd6, 4'd7, 4'd8: nr = row_dn;
      default:          nr = row;
    endcase
    case (k)
      4'd1, 4'd4, 4'd6: nc = col_lf;
      4'd3, 4'd5, 4'd8: nc = col_rt;
      default:          nc = col;
    endcase
  end
  assign nb_idx = CELL_W'(32'(nr) * GRID_SIDE + 32'(nc));

  // Load address and range check.
  assign ld_in  = (32'(cmd.cell_x) < 32'(GRID_SIDE)) && (32'(cmd.cell_y) < 32'(GRID_SIDE));
  assign ld_idx = CELL_W'(32'(cmd.cell_x) * GRID_SIDE + 32'(cmd.cell_y));

  // Exact compare r * 65535 <= p_infec * rmax, done with shifts and subtracts.
  assign rmax  = (CMP_W'(1) << RANDOM_BITS) - CMP_W'(1);
  assign r_val = CMP_W'(cmd.random_value) & rmax;
  assign lhs   = (r_val << 16) - r_val;
  assign rhs   = (CMP_W'(cfg.p_infec) << RANDOM_BITS) - CMP_W'(cfg.p_infec);

  // Next state and timer update of the current cell.
  always_comb begin
    nxt   = own;
    t_wr  = 1'b0;
    t_val = cfg.tau;
    case (own)
      ST_HEALTHY: begin
        if ((na >= cfg.threshold_a) || (nb >= cfg.threshold_b)) begin
          nxt  = ST_A;
          t_wr = 1'b1;
        end
      end
      ST_A: begin
        if (t_rdata != '0) begin
          t_wr  = 1'b1;
          t_val = t_rdata - 1'b1;
        end else begin
          nxt = ST_B;
        end
      end
      ST_B: begin
        nxt = ST_DEAD;
      end
      default: begin
        if (lhs <= rhs) begin
          nxt  = ST_A;
          t_wr = 1'b1;
        end else begin
          nxt = ST_HEALTHY;
        end
      end
    endcase
  end

  // Running counts including the cell being written.
  assign last_cell  = (idx == CELL_W'(CELLS - 1));
  assign run_h_next = run_h + COUNT_W'(nxt == ST_HEALTHY);
  assign run_d_next = run_d + COUNT_W'(nxt == ST_DEAD);
  assign run_i_next = run_i + COUNT_W'((nxt == ST_A) || (nxt == ST_B));

  // Memory port selection.
  always_comb begin
    g_we    = 1'b0;
    g_addr  = {bank, nb_idx};
    g_wdata = nxt;
    t_we    = 1'b0;
    t_addr  = idx;
    t_wdata = t_val;
    case (state)
      S_CLR: begin
        g_we    = 1'b1;
        g_addr  = clr_cnt;
        g_wdata = ST_HEALTHY;
      end
      S_LOAD: begin
        g_we    = ld_in;
        g_addr  = {bank, ld_idx};
        g_wdata = cmd.load_state;
        t_we    = ld_in;
        t_addr  = ld_idx;
        t_wdata = cfg.tau;
      end
      S_EXEC: begin
        g_we   = 1'b1;
        g_addr = {~bank, idx};
        t_we   = t_wr;
      end
      default: begin
        g_we = 1'b0;
      end
    endcase
  end

  // Sequencer with registered results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
      bank    <= 1'b0;
      row     <= '0;
      col     <= '0;
      idx     <= '0;
      k       <= '0;
      rd_vld  <= 1'b0;
      run_h   <= '0;
      run_i   <= '0;
      run_d   <= '0;
      done    <= 1'b0;
    end else begin
      done   <= 1'b0;
      rd_vld <= (state == S_RD);
      rd_k   <= k;
      // Collect read data in the cycle after each address.
      if (rd_vld) begin
        if (rd_k == 4'd0) begin
          own <= g_rdata;
        end else if (g_rdata == ST_A) begin
          na <= na + 1'b1;
        end else if (g_rdata == ST_B) begin
          nb <= nb + 1'b1;
        end
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd   <= q_data;
            k     <= '0;
            na    <= '0;
            nb    <= '0;
            state <= q_data.is_update ? S_RD : S_LOAD;
          end
        end
        S_LOAD: begin
          done            <= 1'b1;
          new_cell_state  <= cmd.load_state;
          generation_done <= 1'b0;
          healthy_count   <= '0;
          infected_count  <= '0;
          dead_count      <= '0;
          state           <= S_IDLE;
        end
        S_RD: begin
          k <= k + 1'b1;
          if (k == 4'd8) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          done            <= 1'b1;
          new_cell_state  <= nxt;
          generation_done <= last_cell;
          healthy_count   <= last_cell ? run_h_next : '0;
          infected_count  <= last_cell ? run_i_next : '0;
          dead_count      <= last_cell ? run_d_next : '0;
          if (last_cell) begin
            bank  <= ~bank;
            idx   <= '0;
            row   <= '0;
            col   <= '0;
            run_h <= '0;
            run_i <= '0;
            run_d <= '0;
          end else begin
            idx   <= idx + 1'b1;
            run_h <= run_h_next;
            run_i <= run_i_next;
            run_d <= run_d_next;
            if (col == ROW_W'(GRID_SIDE - 1)) begin
              col <= '0;
              row <= row + 1'b1;
            end else begin
              col <= col + 1'b1;
            end
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  icas_ram #(.WIDTH(STATE_W), .DEPTH(1 << GADR_W)) u_grid (
    .clk   (clk),
    .we    (g_we),
    .addr  (g_addr),
    .wdata (g_wdata),
    .rdata (g_rdata)
  );

  icas_ram #(.WIDTH(TIMER_W), .DEPTH(1 << CELL_W)) u_timer (
    .clk   (clk),
    .we    (t_we),
    .addr  (t_addr),
    .wdata (t_wdata),
    .rdata (t_rdata)
  );

endmodule

FILE: src/infection_cellular_automaton_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infection_cellular_automaton_step_top
// Two-bank toroidal infection automaton, advanced one cell per update command.
// ----------------------------------------------------------------------------
// The sequencer takes each command from the queue; a load then writes the
// cell, while an update makes nine reads of the single-port grid memory (the
// cell and its eight neighbors), waits for the last read data to land, and
// writes the new state to the other bank. Up to two commands queue in front of
// the sequencer. After reset all 2^(clog2(GRID_SIDE^2)+1) entries of the grid
// memory (8192 at the default size) are swept to healthy, one entry a cycle,
// and busy stays high meanwhile. Each result appears for a single cycle with
// done; the receiver cannot stall it.
`include "assert_macros.svh"

module infection_cellular_automaton_step_top
  import icas_pkg::*;
#(
  parameter int GRID_SIDE   = GRID_SIDE_DEF,
  parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  mode,
  input  logic [COORD_W-1:0]    cell_x,
  input  logic [COORD_W-1:0]    cell_y,
  input  logic [STATE_W-1:0]    load_state,
  input  logic [RAND_W-1:0]     random_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic [STATE_W-1:0]    new_cell_state,
  output logic                  generation_done,
  output logic [COUNT_W-1:0]    healthy_count,
  output logic [COUNT_W-1:0]    infected_count,
  output logic [COUNT_W-1:0]    dead_count
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;

  cfg_t               cfg;
  logic               q_valid;
  cmd_t               q_data;
  logic               q_pop;
  back_stat_t         stat;
  logic [COUNT_W-1:0] gen_total;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_a <= 4'd1;
      cfg.threshold_b <= 4'd4;
      cfg.tau         <= 4'd4;
      cfg.p_infec     <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD_A: cfg.threshold_a <= cfg_data[THR_W-1:0];
        CFG_THRESHOLD_B: cfg.threshold_b <= cfg_data[THR_W-1:0];
        CFG_TAU:         cfg.tau         <= cfg_data[TIMER_W-1:0];
        CFG_P_INFEC:     cfg.p_infec     <= cfg_data[PROB_W-1:0];
        default:         cfg.tau         <= cfg.tau;
      endcase
    end
  end

  icas_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .mode         (mode),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .load_state   (load_state),
    .random_value (random_value),
    .busy         (busy),
    .stat         (stat),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop)
  );

  icas_back #(.GRID_SIDE(GRID_SIDE), .RANDOM_BITS(RANDOM_BITS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .stat            (stat),
    .done            (done),
    .new_cell_state  (new_cell_state),
    .generation_done (generation_done),
    .healthy_count   (healthy_count),
    .infected_count  (infected_count),
    .dead_count      (dead_count)
  );

  // Sum of the reported counts, wrapping like the counters themselves.
  assign gen_total = healthy_count + infected_count + dead_count;

  // Checks on the sequencing and the generation totals.
  `ICAS_NEVER(a_no_done_clearing, stat.clearing && done, "result during clearing pass")
  `ICAS_ASSERT(a_busy_clearing, !stat.clearing || busy, "not busy during clearing pass")
  `ICAS_ASSERT(a_gen_has_done, !generation_done || done, "generation_done without done")
  `ICAS_ASSERT(a_gen_total, !(done && generation_done) || (gen_total == COUNT_W'(CELLS)), "generation counts do not add up")

endmodule

FILE: tb/sv/tb_infection_cellular_automaton_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_infection_cellular_automaton_step_top
// Self-checking bench for the two-bank infection automaton. A queue of cell
// loads and raster updates feeds a bursty driver. A mirror of the grid, the
// timers and the generation counters predicts every done transaction, and a
// monitor compares each one field by field. Loads seed the grid and stretches
// of raster updates run under several threshold, timer and probability
// settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_infection_cellular_automaton_step_top;
  import icas_pkg::*;

  localparam int SIDE  = 64;
  localparam int CELLS = SIDE * SIDE;

  typedef struct {
    logic               is_update;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [STATE_W-1:0] ld_state;
    logic [RAND_W-1:0]  rnd;
  } cell_cmd_t;

  typedef struct {
    logic [STATE_W-1:0] cell_state;
    logic               gen_done;
    logic [COUNT_W-1:0] n_healthy;
    logic [COUNT_W-1:0] n_infected;
    logic [COUNT_W-1:0] n_dead;
  } cell_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  mode = 1'b0;
  logic [COORD_W-1:0]    cell_x = '0;
  logic [COORD_W-1:0]    cell_y = '0;
  logic [STATE_W-1:0]    load_state = '0;
  logic [RAND_W-1:0]     random_value = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  done;
  logic [STATE_W-1:0]    new_cell_state;
  logic                  generation_done;
  logic [COUNT_W-1:0]    healthy_count;
  logic [COUNT_W-1:0]    infected_count;
  logic [COUNT_W-1:0]    dead_count;

  infection_cellular_automaton_step_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .cell_x(cell_x), .cell_y(cell_y), .load_state(load_state),
    .random_value(random_value), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .new_cell_state(new_cell_state), .generation_done(generation_done),
    .healthy_count(healthy_count), .infected_count(infected_count),
    .dead_count(dead_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the block state.
  logic [STATE_W-1:0] grid_mirror [2][CELLS];
  logic [TIMER_W-1:0] timer_mirror [CELLS];
  logic               live_bank;
  int unsigned        raster_pos;
  int unsigned        tally_healthy, tally_infected, tally_dead;
  cfg_t               live_cfg;

  cell_cmd_t    cmd_backlog [$];
  cell_result_t expected_results [$];
  int           error_count = 0;
  int unsigned  updates_queued = 0;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Applies one accepted transaction to the mirror and queues its result.
  task automatic advance_automaton(input cell_cmd_t c);
    cell_result_t res;
    int unsigned idx, r, k, na, nb;
    logic [STATE_W-1:0] cur, nxt, ns;
    res = '{default: '0};
    if (!c.is_update) begin
      idx = c.row * SIDE + c.col;
      grid_mirror[live_bank][idx] = c.ld_state;
      timer_mirror[idx] = live_cfg.tau;
      res.cell_state = c.ld_state;
    end else begin
      idx = raster_pos;
      r = idx / SIDE;
      k = idx % SIDE;
      cur = grid_mirror[live_bank][idx];
      nxt = cur;
      case (cur)
        ST_HEALTHY: begin
          na = 0;
          nb = 0;
          for (int dr = SIDE - 1; dr <= SIDE + 1; dr++)
            for (int dc = SIDE - 1; dc <= SIDE + 1; dc++)
              if (!(dr == SIDE && dc == SIDE)) begin
                ns = grid_mirror[live_bank][((r + dr) % SIDE) * SIDE + (k + dc) % SIDE];
                if (ns == ST_A) na++;
                else if (ns == ST_B) nb++;
              end
          if (na >= live_cfg.threshold_a || nb >= live_cfg.threshold_b) begin
            nxt = ST_A;
            timer_mirror[idx] = live_cfg.tau;
          end
        end
        ST_A: begin
          if (timer_mirror[idx] != 0) timer_mirror[idx] = timer_mirror[idx] - 1'b1;
          else nxt = ST_B;
        end
        ST_B: nxt = ST_DEAD;
        default: begin
          // Both sides scale by the same full-range value, so compare raw.
          if (c.rnd <= live_cfg.p_infec) begin
            nxt = ST_A;
            timer_mirror[idx] = live_cfg.tau;
          end else begin
            nxt = ST_HEALTHY;
          end
        end
      endcase
      grid_mirror[!live_bank][idx] = nxt;
      if (nxt == ST_HEALTHY) tally_healthy++;
      else if (nxt == ST_DEAD) tally_dead++;
      else tally_infected++;
      res.cell_state = nxt;
      if (idx == CELLS - 1) begin
        res.gen_done   = 1'b1;
        res.n_healthy  = tally_healthy[COUNT_W-1:0];
        res.n_infected = tally_infected[COUNT_W-1:0];
        res.n_dead     = tally_dead[COUNT_W-1:0];
        live_bank = !live_bank;
        raster_pos = 0;
        tally_healthy = 0;
        tally_infected = 0;
        tally_dead = 0;
      end else begin
        raster_pos = idx + 1;
      end
    end
    expected_results.push_back(res);
  endtask

  // Driver: bursts of commands separated by random gaps.
  int        burst_left = 0;
  int        gap_left = 0;
  bit        steady = 1'b0;
  cell_cmd_t shown;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) advance_automaton(shown);
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        shown = cmd_backlog.pop_front();
        start        <= 1'b1;
        mode         <= shown.is_update;
        cell_x       <= shown.row;
        cell_y       <= shown.col;
        load_state   <= shown.ld_state;
        random_value <= shown.rnd;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = steady ? 0 : $urandom_range(1, 8);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every done transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    cell_result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report("done transaction with no prediction waiting");
      end else begin
        want = expected_results.pop_front();
        if (new_cell_state !== want.cell_state)
          report($sformatf("new_cell_state %0d, predicted %0d", new_cell_state,
                           want.cell_state));
        if (generation_done !== want.gen_done)
          report($sformatf("generation_done %0b, predicted %0b", generation_done,
                           want.gen_done));
        if (healthy_count !== want.n_healthy)
          report($sformatf("healthy_count %0d, predicted %0d", healthy_count,
                           want.n_healthy));
        if (infected_count !== want.n_infected)
          report($sformatf("infected_count %0d, predicted %0d", infected_count,
                           want.n_infected));
        if (dead_count !== want.n_dead)
          report($sformatf("dead_count %0d, predicted %0d", dead_count, want.n_dead));
      end
    end
  end

  task automatic push_load(input int r, input int k, input int s);
    cell_cmd_t c;
    c.is_update = 1'b0;
    c.row = COORD_W'(r);
    c.col = COORD_W'(k);
    c.ld_state = STATE_W'(s);
    c.rnd = RAND_W'($urandom_range(0, 16'hFFFF));
    cmd_backlog.push_back(c);
  endtask

  task automatic push_update(input logic [RAND_W-1:0] rv);
    cell_cmd_t c;
    c.is_update = 1'b1;
    c.row = COORD_W'($urandom_range(0, SIDE - 1));
    c.col = COORD_W'($urandom_range(0, SIDE - 1));
    c.ld_state = STATE_W'($urandom_range(0, 3));
    c.rnd = rv;
    cmd_backlog.push_back(c);
    updates_queued++;
  endtask

  task automatic push_random_load();
    push_load($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
              $urandom_range(0, 3));
  endtask

  // Updates with an occasional load mixed in, until n updates are queued.
  task automatic push_mixed(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 4) push_random_load();
      push_update(RAND_W'($urandom_range(0, 16'hFFFF)));
    end
  endtask

  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || expected_results.size() != 0 || start)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_THRESHOLD_A: live_cfg.threshold_a = val[THR_W-1:0];
      CFG_THRESHOLD_B: live_cfg.threshold_b = val[THR_W-1:0];
      CFG_TAU:         live_cfg.tau = val[TIMER_W-1:0];
      default:         live_cfg.p_infec = val;
    endcase
  endtask

  task automatic write_all(input int ta, input int tb, input int tu, input int p);
    write_reg(CFG_THRESHOLD_A, CFG_DATA_W'(ta));
    write_reg(CFG_THRESHOLD_B, CFG_DATA_W'(tb));
    write_reg(CFG_TAU, CFG_DATA_W'(tu));
    write_reg(CFG_P_INFEC, CFG_DATA_W'(p));
  endtask

  // Stimulus sequence.
  initial begin
    for (int b = 0; b < 2; b++)
      for (int i = 0; i < CELLS; i++) grid_mirror[b][i] = ST_HEALTHY;
    for (int i = 0; i < CELLS; i++) timer_mirror[i] = '0;
    live_bank = 1'b0;
    raster_pos = 0;
    tally_healthy = 0;
    tally_infected = 0;
    tally_dead = 0;
    live_cfg = '{threshold_a: 4'd1, threshold_b: 4'd4, tau: 4'd4, p_infec: 16'd1};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: loads of every state at the corners and near the origin, then updates with extreme randoms.
    write_all(2, 3, 0, 16'h8000);
    push_load(0, 0, ST_A);
    push_load(0, SIDE - 1, ST_B);
    push_load(SIDE - 1, 0, ST_DEAD);
    push_load(SIDE - 1, SIDE - 1, ST_A);
    push_load(0, 1, ST_HEALTHY);
    push_load(1, 1, ST_B);
    push_load(1, 0, ST_DEAD);
    push_load(2, 2, ST_A);
    push_update(16'h0000);
    push_update(16'hFFFF);
    push_update(16'h8000);
    push_update(16'h8001);
    for (int i = 0; i < 6; i++) push_update(RAND_W'($urandom_range(0, 16'hFFFF)));

    // Seeded grid, bursty driver.
    for (int i = 0; i < 150; i++) push_random_load();
    push_mixed(410 - updates_queued);
    wait_idle();

    // Threshold zero always infects, long timers, dead cells revive only on a zero random value.
    // The sender holds off until everything is drained before the mid-run change.
    write_all(0, 15, 15, 0);
    steady = 1'b1;
    for (int i = 0; i < 80; i++) push_random_load();
    push_mixed(300);
    wait_idle();
    write_all(9, 1, 1, 16'hFFFF);
    steady = 1'b0;
    push_mixed(300);
    wait_idle();

    // Thresholds above eight never infect.
    write_all(15, 9, 15, 16'h7FFF);
    for (int i = 0; i < 100; i++) push_random_load();
    push_mixed(150);
    wait_idle();

    if (error_count == 0) begin
      $display("PASS infection_cellular_automaton_step_top");
    end else begin
      $display("FAIL infection_cellular_automaton_step_top");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL infection_cellular_automaton_step_top");
    $finish;
  end

endmodule
